// ===== hdl/oeaf_pkg.sv =====
// Package: widths, constants, controller codes and command/status types for the one euro filter.
`default_nettype none
package oeaf_pkg;
	localparam int SampleW  = 16;
	localparam int IntervalW = 16;
	localparam int CfgW     = 16;
	localparam int CfgIdxW  = 2;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MIN_CUTOFF  = 2'd0,
		REG_SPEED_GAIN  = 2'd1,
		REG_RATE_CUTOFF = 2'd2
	} cfg_reg_t;

	localparam logic [CfgW-1:0] MIN_CUTOFF_RST  = 16'd1000;
	localparam logic [CfgW-1:0] SPEED_GAIN_RST  = 16'd205;
	localparam logic [CfgW-1:0] RATE_CUTOFF_RST = 16'd1200;

	localparam logic [19:0] RATE_SCALE  = 20'd1000000;
	localparam logic [18:0] TWO_PI_Q16  = 19'd411775;
	localparam logic [46:0] DEN_Q16     = 47'd65536000000000;
	localparam logic [47:0] FCUS_CAP    = 48'd17592186044416;
	localparam logic [30:0] RATE_MAX    = 31'h7FFF_FFFF;
	localparam logic [9:0]  GAIN_SCALE  = 10'd1000;
	localparam logic [15:0] ALPHA_MIN   = 16'd1966;
	localparam logic [15:0] ALPHA_MAX   = 16'd62259;
	localparam logic [5:0]  MAG_STEPS   = 6'd36;
	localparam logic [5:0]  W_STEPS     = 6'd16;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLEAR,
		OP_PASS,
		OP_RATE_NUM,
		OP_DIV_STEP,
		OP_RAW,
		OP_P,
		OP_NORM,
		OP_WDIV_LOAD,
		OP_BLEND_RATE,
		OP_RATE_UPD,
		OP_GAIN,
		OP_GAIN_K,
		OP_FC,
		OP_FCUS_EST,
		OP_BLEND_EST,
		OP_EST_UPD
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_MAGDIV,
		S_RAW,
		S_P,
		S_NORM,
		S_WDIV,
		S_BLEND_RATE,
		S_RATE_UPD,
		S_GAIN,
		S_GAIN_K,
		S_FC,
		S_FCUS,
		S_BLEND_EST,
		S_EST_UPD
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic us_zero;
		logic primed;
		logic div_last;
		logic div_busy;
		logic p_big;
	} stat_t;
endpackage
`default_nettype wire

// ===== hdl/oeaf_if.sv =====
// Interfaces: sample input, filtered output and register write channels.
`default_nettype none
interface oeaf_in_if import oeaf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic signed [SampleW-1:0]  sample;
	logic [IntervalW-1:0]       interval_us;
	modport source (output valid, kind, sample, interval_us, input ready);
	modport sink (input valid, kind, sample, interval_us, output ready);
endinterface

interface oeaf_out_if import oeaf_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [SampleW-1:0] filtered;
	modport source (output valid, filtered, input ready);
	modport sink (input valid, filtered, output ready);
endinterface

interface oeaf_cfg_if import oeaf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [CfgW-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/oeaf_ctrl.sv =====
// Controller: sequences the datapath operations for one item and owns the output valid.
`default_nettype none
module oeaf_ctrl import oeaf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);
	state_t state_q, state_nx;
	logic   phase_q;
	logic   out_valid_q;
	logic   set_out;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_DECIDE)
				phase_q <= 1'b0;
			else if (state_q == S_FCUS)
				phase_q <= 1'b1;
			if (set_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd.op   = OP_NONE;
		set_out  = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op   = OP_LOAD;
					state_nx = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.kind) begin
					cmd.op   = OP_CLEAR;
					state_nx = S_IDLE;
				end else if (stat.us_zero || !stat.primed) begin
					if (out_free) begin
						cmd.op   = OP_PASS;
						set_out  = 1'b1;
						state_nx = S_IDLE;
					end
				end else begin
					cmd.op   = OP_RATE_NUM;
					state_nx = S_MAGDIV;
				end
			end
			S_MAGDIV: begin
				cmd.op = OP_DIV_STEP;
				if (stat.div_last)
					state_nx = S_RAW;
			end
			S_RAW: begin
				cmd.op   = OP_RAW;
				state_nx = S_P;
			end
			S_P: begin
				cmd.op   = OP_P;
				state_nx = S_NORM;
			end
			S_NORM: begin
				if (stat.p_big) begin
					cmd.op = OP_NORM;
				end else begin
					cmd.op   = OP_WDIV_LOAD;
					state_nx = S_WDIV;
				end
			end
			S_WDIV: begin
				cmd.op = OP_DIV_STEP;
				if (stat.div_last)
					state_nx = phase_q ? S_BLEND_EST : S_BLEND_RATE;
			end
			S_BLEND_RATE: begin
				cmd.op   = OP_BLEND_RATE;
				state_nx = S_RATE_UPD;
			end
			S_RATE_UPD: begin
				cmd.op   = OP_RATE_UPD;
				state_nx = S_GAIN;
			end
			S_GAIN: begin
				cmd.op   = OP_GAIN;
				state_nx = S_GAIN_K;
			end
			S_GAIN_K: begin
				cmd.op   = OP_GAIN_K;
				state_nx = S_FC;
			end
			S_FC: begin
				cmd.op   = OP_FC;
				state_nx = S_FCUS;
			end
			S_FCUS: begin
				cmd.op   = OP_FCUS_EST;
				state_nx = S_P;
			end
			S_BLEND_EST: begin
				cmd.op   = OP_BLEND_EST;
				state_nx = S_EST_UPD;
			end
			S_EST_UPD: begin
				if (out_free) begin
					cmd.op   = OP_EST_UPD;
					set_out  = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/oeaf_dp.sv =====
// Datapath: config registers, filter state, shared shift-subtract divider and multipliers.
`default_nettype none
module oeaf_dp import oeaf_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cmd_t                      cmd,
	output stat_t                          stat,
	input  wire logic                      in_kind,
	input  wire logic signed [SampleW-1:0] in_sample,
	input  wire logic [IntervalW-1:0]      in_interval,
	input  wire logic                      cfg_we,
	input  wire logic [CfgIdxW-1:0]        cfg_index,
	input  wire logic [CfgW-1:0]           cfg_data,
	output logic signed [SampleW-1:0]      filtered
);
	logic [CfgW-1:0] min_cutoff_q, speed_gain_q, rate_cutoff_q;

	logic signed [SampleW-1:0] last_q;
	logic signed [31:0]        rate_q;
	logic                      primed_q;

	logic                      kind_q;
	logic signed [SampleW-1:0] x_q;
	logic [IntervalW-1:0]      us_q;
	logic                      neg_q;
	logic signed [31:0]        raw_q;
	logic [47:0]               fcus_q;
	logic [62:0]               p_q;
	logic [46:0]               d_q;
	logic signed [49:0]        rprod_q;
	logic [57:0]               gain_q;
	logic [31:0]               fc_q;
	logic signed [33:0]        eprod_q;
	logic signed [SampleW-1:0] filt_q;

	// divider
	logic [47:0] rem_q;
	logic [35:0] num_q;
	logic [35:0] quo_q;
	logic [47:0] den_q;
	logic [5:0]  cnt_q;

	logic signed [16:0] ediff;
	logic [15:0]        absd;
	logic [35:0]        rate_num;
	logic [48:0]        rsh;
	logic               ge;
	logic [48:0]        rsub;
	logic [30:0]        mag;
	logic [15:0]        w;
	logic [15:0]        wc;
	logic [44:0]        capped;
	logic signed [32:0] rdiff;
	logic signed [16:0] wext;
	logic signed [16:0] wcext;
	logic signed [49:0] rprod;
	logic signed [33:0] eprod;
	logic [31:0]        rate_abs;
	logic [37:0]        fc_sum;
	logic signed [17:0] est;
	logic signed [SampleW-1:0] est_sat;

	always_comb begin
		ediff    = {x_q[15], x_q} - {last_q[15], last_q};
		absd     = ediff[16] ? 16'(-ediff) : ediff[15:0];
		rate_num = 36'(absd * RATE_SCALE);
		rsh      = {rem_q, num_q[35]};
		ge       = rsh >= {1'b0, den_q};
		rsub     = rsh - {1'b0, den_q};
		mag      = (quo_q[35:31] != 5'd0) ? RATE_MAX : quo_q[30:0];
		w        = quo_q[15:0];
		if (w > ALPHA_MAX)
			wc = ALPHA_MAX;
		else if (w < ALPHA_MIN)
			wc = ALPHA_MIN;
		else
			wc = w;
		capped   = (fcus_q > FCUS_CAP) ? FCUS_CAP[44:0] : fcus_q[44:0];
		rdiff    = {raw_q[31], raw_q} - {rate_q[31], rate_q};
		wext     = $signed({1'b0, w});
		wcext    = $signed({1'b0, wc});
		rprod    = wext * rdiff;
		eprod    = wcext * ediff;
		rate_abs = rate_q[31] ? 32'(-rate_q) : rate_q;
		fc_sum   = {22'd0, min_cutoff_q} + gain_q[57:20];
		est      = {{2{last_q[15]}}, last_q} + eprod_q[33:16];
		if (est[17:15] == 3'b000 || est[17:15] == 3'b111)
			est_sat = est[15:0];
		else
			est_sat = est[17] ? 16'sh8000 : 16'sh7FFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_cutoff_q  <= MIN_CUTOFF_RST;
			speed_gain_q  <= SPEED_GAIN_RST;
			rate_cutoff_q <= RATE_CUTOFF_RST;
			last_q        <= '0;
			rate_q        <= '0;
			primed_q      <= 1'b0;
			cnt_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_CUTOFF:  min_cutoff_q  <= cfg_data;
					REG_SPEED_GAIN:  speed_gain_q  <= cfg_data;
					REG_RATE_CUTOFF: rate_cutoff_q <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.op)
				OP_CLEAR: begin
					last_q <= '0;
					rate_q <= '0;
				end
				OP_PASS: begin
					if (us_q != '0) begin
						last_q   <= x_q;
						rate_q   <= '0;
						primed_q <= 1'b1;
					end
				end
				OP_RATE_NUM:  cnt_q <= MAG_STEPS;
				OP_WDIV_LOAD: cnt_q <= W_STEPS;
				OP_DIV_STEP:  cnt_q <= cnt_q - 6'd1;
				OP_RATE_UPD:  rate_q <= rate_q + rprod_q[47:16];
				OP_EST_UPD:   last_q <= est_sat;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				kind_q <= in_kind;
				x_q    <= in_sample;
				us_q   <= in_interval;
			end
			OP_PASS: filt_q <= x_q;
			OP_RATE_NUM: begin
				neg_q <= ediff[16];
				rem_q <= '0;
				num_q <= rate_num;
				quo_q <= '0;
				den_q <= {32'd0, us_q};
			end
			OP_DIV_STEP: begin
				rem_q <= ge ? rsub[47:0] : rsh[47:0];
				num_q <= {num_q[34:0], 1'b0};
				quo_q <= {quo_q[34:0], ge};
			end
			OP_RAW: begin
				raw_q  <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
				fcus_q <= {16'd0, 32'(rate_cutoff_q) * 32'(us_q)};
			end
			OP_P: begin
				p_q <= 63'(capped * TWO_PI_Q16);
				d_q <= DEN_Q16;
			end
			OP_NORM: begin
				p_q <= p_q >> 1;
				d_q <= d_q >> 1;
			end
			OP_WDIV_LOAD: begin
				rem_q <= p_q[47:0];
				num_q <= '0;
				quo_q <= '0;
				den_q <= p_q[47:0] + {1'b0, d_q};
			end
			OP_BLEND_RATE: rprod_q <= rprod;
			OP_GAIN:       gain_q  <= {10'd0, 48'(speed_gain_q) * 48'(rate_abs)};
			OP_GAIN_K:     gain_q  <= 58'(gain_q[47:0] * GAIN_SCALE);
			OP_FC:         fc_q    <= (fc_sum[37:32] != 6'd0) ? 32'hFFFF_FFFF : fc_sum[31:0];
			OP_FCUS_EST:   fcus_q  <= fc_q * us_q;
			OP_BLEND_EST:  eprod_q <= eprod;
			OP_EST_UPD:    filt_q  <= est_sat;
			default: ;
		endcase
	end

	assign filtered = filt_q;

	always_comb begin
		stat.kind     = kind_q;
		stat.us_zero  = us_q == '0;
		stat.primed   = primed_q;
		stat.div_last = cnt_q == 6'd1;
		stat.div_busy = cnt_q != 6'd0;
		stat.p_big    = p_q[62:47] != 16'd0;
	end
endmodule
`default_nettype wire

// ===== hdl/one_euro_adaptive_filter.sv =====
// Top level: one euro adaptive low-pass filter, controller plus datapath.
// Usage:
//   samples carries items (kind, sample Q7.8, interval_us). kind 1 clears the
//   history and yields no result; a zero interval or the first sample after
//   reset is passed straight through (the latter also seeds the history).
//   results carries one filtered Q7.8 value per sample item.
//   cfg writes min_cutoff_mhz (0), speed_gain (1), rate_cutoff_mhz (2); other
//   indexes are dropped. cfg is always ready; write only while idle.
// Sequencing:
//   One item at a time. A filtered sample runs through the shared shift-subtract
//   divider (36 steps for the rate, 16 steps for each of two weights) and the
//   normalize shifts: up to four for the rate weight and up to sixteen for the
//   sample weight. A new item is taken once the controller is back in idle.
// Reset: arst_n clears the history, the primed flag and the registers to
//   their defaults. If results stalls, the finished value stays in the output
//   register; the next item may be accepted and runs until its own result is
//   due, then waits for the register to free up.
`default_nettype none
module one_euro_adaptive_filter import oeaf_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	oeaf_in_if.sink    samples,
	oeaf_out_if.source results,
	oeaf_cfg_if.sink   cfg
);
	cmd_t  cmd;
	stat_t stat;

	assign cfg.ready = 1'b1;

	oeaf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	oeaf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_kind     (samples.kind),
		.in_sample   (samples.sample),
		.in_interval (samples.interval_us),
		.cfg_we      (cfg.valid && cfg.ready),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.filtered    (results.filtered)
	);

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> !samples.ready)
		else $error("input taken while an item is in work");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DIV_STEP |-> stat.div_busy)
		else $error("divider stepped with no steps left");

	a_norm_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_WDIV_LOAD |-> !stat.p_big)
		else $error("weight division started before normalization");
endmodule
`default_nettype wire

// ===== verif/one_euro_adaptive_filter_tb.sv =====
// Testbench for the one euro adaptive filter: random and directed items checked against a predictor.
`default_nettype none
class filt_scoreboard;
	logic [15:0] min_cut;
	logic [15:0] gain;
	logic [15:0] rate_cut;
	logic signed [31:0] est_hist;
	logic signed [31:0] rate_hist;
	bit primed;
	logic signed [15:0] expected_q[$];
	int errors;

	function new();
		min_cut = 16'd1000;
		gain = 16'd205;
		rate_cut = 16'd1200;
		est_hist = 0;
		rate_hist = 0;
		primed = 0;
		errors = 0;
	endfunction

	function void set_reg(oeaf_pkg::cfg_reg_t idx, logic [15:0] val);
		case (idx)
			oeaf_pkg::REG_MIN_CUTOFF: min_cut = val;
			oeaf_pkg::REG_SPEED_GAIN: gain = val;
			oeaf_pkg::REG_RATE_CUTOFF: rate_cut = val;
			default: ;
		endcase
	endfunction

	function longint weight(longint unsigned fcus);
		longint unsigned p, d;
		if (fcus > 64'd17592186044416) fcus = 64'd17592186044416;
		p = fcus * 64'd411775;
		d = 64'd1000000000 << 16;
		while (p >= (64'd1 << 47)) begin
			p = p >> 1;
			d = d >> 1;
		end
		return longint'((p << 16) / (p + d));
	endfunction

	function longint mix(longint w, longint a, longint b);
		longint v;
		v = w * a + (65536 - w) * b;
		return v >>> 16;
	endfunction

	function void note_input(bit kind, logic signed [15:0] x, logic [15:0] us);
		longint diff, raw, rt, w, e;
		longint unsigned mag, fc;
		if (kind) begin
			est_hist = 0;
			rate_hist = 0;
			return;
		end
		if (us == 0) begin
			expected_q.push_back(x);
			return;
		end
		if (!primed) begin
			est_hist = x;
			rate_hist = 0;
			primed = 1;
			expected_q.push_back(x);
			return;
		end
		diff = longint'(x) - longint'(est_hist);
		mag = longint'(diff < 0 ? -diff : diff) * 1000000 / us;
		if (mag > 64'd2147483647) mag = 64'd2147483647;
		raw = diff < 0 ? -longint'(mag) : longint'(mag);
		w = weight(longint'(rate_cut) * us);
		rt = mix(w, raw, rate_hist);
		rate_hist = rt;
		mag = rt < 0 ? -rt : rt;
		fc = longint'(min_cut) + ((longint'(gain) * mag * 1000) >> 20);
		if (fc > 64'hFFFFFFFF) fc = 64'hFFFFFFFF;
		w = weight(fc * us);
		if (w > 62259) w = 62259;
		if (w < 1966) w = 1966;
		e = mix(w, x, est_hist);
		if (e > 32767) e = 32767;
		if (e < -32768) e = -32768;
		est_hist = e;
		expected_q.push_back(e[15:0]);
	endfunction

	task check_result(logic signed [15:0] got);
		logic signed [15:0] exp_val;
		if (expected_q.size() == 0) begin
			report_err($sformatf("unexpected result %0d", got));
			return;
		end
		exp_val = expected_q.pop_front();
		if (got !== exp_val)
			report_err($sformatf("filtered %0d, expected %0d", got, exp_val));
	endtask

	task report_err(string msg);
		$display("ERROR: %s", msg);
		errors++;
	endtask
endclass

module one_euro_adaptive_filter_tb;
	import oeaf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;

	logic clk = 0;
	logic arst_n = 0;
	int idle_cycles = 0;
	filt_scoreboard sb;

	oeaf_in_if samp_ch();
	oeaf_out_if res_ch();
	oeaf_cfg_if cfg_ch();

	one_euro_adaptive_filter u_dut (
		.clk(clk), .arst_n(arst_n),
		.samples(samp_ch.sink), .results(res_ch.source), .cfg(cfg_ch.sink)
	);

	always #5 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 120);
	endfunction

	// result side: random stalls, check on accept
	initial begin
		res_ch.ready <= 0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.filtered);
			res_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		if ((samp_ch.valid && samp_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("FAIL one_euro_adaptive_filter");
			$finish;
		end
	end

	// valid stays high after the accept; it drops only for a gap or in drain
	task automatic send_item(bit kind, logic signed [15:0] x, logic [15:0] us);
		int g;
		g = gap_len();
		if (g > 0) begin
			samp_ch.valid <= 0;
			repeat (g) @(posedge clk);
		end
		samp_ch.valid <= 1;
		samp_ch.kind <= kind;
		samp_ch.sample <= x;
		samp_ch.interval_us <= us;
		do @(posedge clk); while (!samp_ch.ready);
		sb.note_input(kind, x, us);
	endtask

	task automatic drain();
		samp_ch.valid <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, val);
	endtask

	task automatic set_all(logic [15:0] a, logic [15:0] b, logic [15:0] c);
		write_reg(REG_MIN_CUTOFF, a);
		write_reg(REG_SPEED_GAIN, b);
		write_reg(REG_RATE_CUTOFF, c);
		cfg_ch.valid <= 0;
	endtask

	task automatic random_items(int n);
		logic signed [15:0] x;
		logic [15:0] us;
		int r;
		x = 16'($urandom);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				// trajectory-like samples at short intervals
				x = x + $signed(16'($urandom_range(0, 1023))) - 16'sd512;
				us = 16'($urandom_range(1000, 20000));
			end else begin
				x = 16'($urandom);
				us = (r < 80) ? 16'd0 : 16'($urandom);
			end
			send_item((r >= 97), x, us);
		end
	endtask

	initial begin
		sb = new();
		samp_ch.valid <= 0;
		samp_ch.kind <= 0;
		samp_ch.sample <= 0;
		samp_ch.interval_us <= 0;
		cfg_ch.valid <= 0;
		cfg_ch.index <= REG_MIN_CUTOFF;
		cfg_ch.data <= 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: passthroughs, priming, extremes, clear
		send_item(0, 16'sh7FFF, 16'd0);
		send_item(1, 16'sd0, 16'd5);
		send_item(0, -16'sd32768, 16'd1000);
		send_item(0, 16'sh7FFF, 16'd1);
		send_item(0, 16'sh7FFF, 16'hFFFF);
		send_item(0, -16'sd32768, 16'hFFFF);
		send_item(0, 16'sd100, 16'd0);
		send_item(1, 16'sh7FFF, 16'hFFFF);
		send_item(0, 16'sh7FFF, 16'd1);
		send_item(0, 16'sd256, 16'd5000);
		send_item(0, -16'sd256, 16'd5000);
		drain();
		set_all(16'd0, 16'd0, 16'd0);
		send_item(0, 16'sd1000, 16'd5000);
		send_item(0, -16'sd1000, 16'd10);
		drain();
		set_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(0, 16'sh7FFF, 16'hFFFF);
		send_item(0, -16'sd32768, 16'hFFFF);
		send_item(0, 16'sd5, 16'd1);
		drain();
		set_all(16'd1000, 16'd205, 16'd1200);
		random_items(250);
		drain();
		set_all(16'($urandom), 16'($urandom), 16'($urandom));
		random_items(250);
		drain();
		set_all(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 8000)),
			16'($urandom_range(0, 3000)));
		random_items(250);
		drain();
		if (sb.errors == 0)
			$display("PASS one_euro_adaptive_filter");
		else
			$display("FAIL one_euro_adaptive_filter");
		$finish;
	end
endmodule
`default_nettype wire

// ===== one_euro_adaptive_filter.f =====
hdl/oeaf_pkg.sv
hdl/oeaf_if.sv
hdl/oeaf_ctrl.sv
hdl/oeaf_dp.sv
hdl/one_euro_adaptive_filter.sv
verif/one_euro_adaptive_filter_tb.sv
